[src/b64v_pkg.sv]
// Package for the base64 variant codec: result record type, alphabet constants
// and the character mapping functions shared by the codec logic.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package b64v_pkg;

    // One result as it leaves the block.
    typedef struct packed {
        logic [7:0] value;
        logic       last;
        logic       err;
    } b64v_res_t;

    // Character codes of the two punctuation symbols at the end of the alphabet.
    localparam logic [5:0] CODE_HASH = 6'd62;
    localparam logic [5:0] CODE_DASH = 6'd63;

    // Start of the lowercase and digit ranges in the code space.
    localparam logic [5:0] CODE_LOWER = 6'd26;
    localparam logic [5:0] CODE_DIGIT = 6'd52;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_HASH    = 8'h23;
    localparam logic [7:0] CHAR_DASH    = 8'h2d;

    // Maps a 6-bit code to its ASCII character.
    function automatic logic [7:0] enc_char(input logic [5:0] code);
        logic [7:0] ext;
        ext = {2'b00, code};
        if (code < CODE_LOWER) begin
            enc_char = CHAR_UPPER_A + ext;
        end else if (code < CODE_DIGIT) begin
            enc_char = CHAR_LOWER_A + ext - {2'b00, CODE_LOWER};
        end else if (code == CODE_HASH) begin
            enc_char = CHAR_HASH;
        end else if (code == CODE_DASH) begin
            enc_char = CHAR_DASH;
        end else begin
            enc_char = CHAR_ZERO + ext - {2'b00, CODE_DIGIT};
        end
    endfunction

    // Maps an ASCII character to {invalid flag, 6-bit code}.
    function automatic logic [6:0] dec_char(input logic [7:0] ch);
        logic [7:0] off;
        off = 8'd0;
        if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z) begin
            off = ch - CHAR_UPPER_A;
            dec_char = {1'b0, off[5:0]};
        end else if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) begin
            off = ch - CHAR_LOWER_A + {2'b00, CODE_LOWER};
            dec_char = {1'b0, off[5:0]};
        end else if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
            off = ch - CHAR_ZERO + {2'b00, CODE_DIGIT};
            dec_char = {1'b0, off[5:0]};
        end else if (ch == CHAR_HASH) begin
            dec_char = {1'b0, CODE_HASH};
        end else if (ch == CHAR_DASH) begin
            dec_char = {1'b0, CODE_DASH};
        end else begin
            dec_char = {1'b1, 6'd0};
        end
    endfunction

endpackage

`default_nettype wire

[src/base64_variant_codec.sv]
// Top level of the base64 variant codec: input register, group state,
// encode/decode logic and the output register.
// Depends on b64v_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
// The s_ channel carries one item per transfer: a data byte when encoding or
// an ASCII character when decoding, with s_tlast on the final item of a string.
// The m_ channel carries results: a character or a decoded byte in m_tdata,
// m_tlast on the final result, and m_tuser set on a decode error (which also
// carries m_tlast). After an error, input is dropped up to the next s_tlast.
// The cfg_ channel writes the direction bit (0 encode, 1 decode); a write also
// starts a new string. It is taken only while the input register is empty.
// An item's first result reaches m_ through the input register and then the
// output register, which takes one result per cycle while it is free.
// Throughput: one item per cycle when it makes zero or one result and the
// receiver takes results; an encode item that makes two characters holds the
// input register until its second character enters the output register.
// Reset (aresetn low, synchronous) empties both registers, sets encode mode
// and clears the group state. When the receiver stalls, the output register
// holds its result and the input register fills; s_tready then drops.
module base64_variant_codec (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    // Input channel.
    input  wire logic       s_tvalid,
    output      logic       s_tready,
    input  wire logic [7:0] s_tdata,    // [7:0] item
    input  wire logic       s_tlast,    // item_last
    // Result channel.
    output      logic       m_tvalid,
    input  wire logic       m_tready,
    output      logic [7:0] m_tdata,    // [7:0] value
    output      logic       m_tlast,    // value_last
    output      logic       m_tuser,    // [0] error
    // Configuration channel.
    input  wire logic       cfg_valid,
    output      logic       cfg_ready,
    input  wire logic       cfg_data
);

    // Input register.
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_data_reg;
    logic       in_last_reg;
    logic       sub_reg, sub_next;

    // Group state.
    logic       direction_reg;
    logic [1:0] group_phase_reg, group_phase_next;
    logic [5:0] carry_bits_reg, carry_bits_next;
    logic       failed_reg, failed_next;

    // Output register.
    logic                m_valid_reg, m_valid_next;
    b64v_pkg::b64v_res_t m_res_reg;

    // Work on the held item.
    b64v_pkg::b64v_res_t res0, res1, res_sel;
    logic [1:0] res_count;
    logic       out_free;
    logic       emit;
    logic       consume;
    logic       cfg_write;
    logic       s_accept;

    assign out_free  = !m_valid_reg || m_tready;
    assign cfg_ready = !in_valid_reg;
    assign cfg_write = cfg_valid && cfg_ready;

    // Results and next group state for the held item.
    always_comb begin
        logic [6:0] dec;
        logic [5:0] code;
        res0             = '0;
        res1             = '0;
        res_count        = 2'd0;
        group_phase_next = group_phase_reg;
        carry_bits_next  = carry_bits_reg;
        failed_next      = failed_reg;
        dec              = b64v_pkg::dec_char(in_data_reg);
        code             = dec[5:0];
        if (!direction_reg) begin
            // Encode: each byte gives one or two characters.
            case (group_phase_reg)
                2'd1: begin
                    res0.value = b64v_pkg::enc_char({in_data_reg[3:0], 2'b00} | carry_bits_reg);
                    if (in_last_reg) begin
                        res1.value       = b64v_pkg::enc_char({2'b00, in_data_reg[7:4]});
                        res1.last        = 1'b1;
                        res_count        = 2'd2;
                        group_phase_next = 2'd0;
                        carry_bits_next  = 6'd0;
                    end else begin
                        res_count        = 2'd1;
                        group_phase_next = 2'd2;
                        carry_bits_next  = {2'b00, in_data_reg[7:4]};
                    end
                end
                2'd2: begin
                    res0.value       = b64v_pkg::enc_char({in_data_reg[1:0], 4'b0000}
                                                          | carry_bits_reg);
                    res1.value       = b64v_pkg::enc_char(in_data_reg[7:2]);
                    res1.last        = in_last_reg;
                    res_count        = 2'd2;
                    group_phase_next = 2'd0;
                    carry_bits_next  = 6'd0;
                end
                default: begin
                    res0.value = b64v_pkg::enc_char(in_data_reg[5:0]);
                    if (in_last_reg) begin
                        res1.value       = b64v_pkg::enc_char({4'b0000, in_data_reg[7:6]});
                        res1.last        = 1'b1;
                        res_count        = 2'd2;
                        group_phase_next = 2'd0;
                        carry_bits_next  = 6'd0;
                    end else begin
                        res_count        = 2'd1;
                        group_phase_next = 2'd1;
                        carry_bits_next  = {4'b0000, in_data_reg[7:6]};
                    end
                end
            endcase
        end else if (failed_reg) begin
            // Dropping after an error until the end of the string.
            if (in_last_reg) begin
                group_phase_next = 2'd0;
                carry_bits_next  = 6'd0;
                failed_next      = 1'b0;
            end
        end else if (dec[6] || (group_phase_reg == 2'd0 && in_last_reg)) begin
            // Invalid character or a lone final character.
            res0.last = 1'b1;
            res0.err  = 1'b1;
            res_count = 2'd1;
            if (in_last_reg) begin
                group_phase_next = 2'd0;
                carry_bits_next  = 6'd0;
            end else begin
                failed_next = 1'b1;
            end
        end else begin
            // Decode: rebuild bytes least significant bits first.
            case (group_phase_reg)
                2'd0: begin
                    carry_bits_next  = code;
                    group_phase_next = 2'd1;
                end
                2'd1: begin
                    res0.value       = {code[1:0], 6'd0} | {2'b00, carry_bits_reg};
                    res_count        = 2'd1;
                    carry_bits_next  = {2'b00, code[5:2]};
                    group_phase_next = 2'd2;
                end
                2'd2: begin
                    res0.value       = {code[3:0], 4'd0} | {2'b00, carry_bits_reg};
                    res_count        = 2'd1;
                    carry_bits_next  = {4'b0000, code[5:4]};
                    group_phase_next = 2'd3;
                end
                default: begin
                    res0.value       = {code, 2'b00} | {2'b00, carry_bits_reg};
                    res_count        = 2'd1;
                    carry_bits_next  = 6'd0;
                    group_phase_next = 2'd0;
                end
            endcase
            res0.last = in_last_reg;
            if (in_last_reg) begin
                group_phase_next = 2'd0;
                carry_bits_next  = 6'd0;
            end
        end
    end

    // Step through the held item's results one per cycle while the output register is free.
    always_comb begin
        res_sel       = sub_reg ? res1 : res0;
        emit          = in_valid_reg && (res_count != 2'd0) && out_free;
        consume       = in_valid_reg && ((res_count == 2'd0)
                        || (out_free && (sub_reg == (res_count == 2'd2))));
        s_tready      = !in_valid_reg || consume;
        s_accept      = s_tvalid && s_tready;
        in_valid_next = s_accept ? 1'b1 : (consume ? 1'b0 : in_valid_reg);
        sub_next      = consume ? 1'b0 : (emit ? 1'b1 : sub_reg);
        m_valid_next  = emit ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            sub_reg         <= 1'b0;
            m_valid_reg     <= 1'b0;
            direction_reg   <= 1'b0;
            group_phase_reg <= 2'd0;
            carry_bits_reg  <= 6'd0;
            failed_reg      <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            sub_reg      <= sub_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_write) begin
                direction_reg   <= cfg_data;
                group_phase_reg <= 2'd0;
                carry_bits_reg  <= 6'd0;
                failed_reg      <= 1'b0;
            end else if (consume) begin
                group_phase_reg <= group_phase_next;
                carry_bits_reg  <= carry_bits_next;
                failed_reg      <= failed_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_data_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (emit) begin
            m_res_reg <= res_sel;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_res_reg.value;
    assign m_tlast  = m_res_reg.last;
    assign m_tuser  = m_res_reg.err;

`ifndef SYNTHESIS
    // The second result slot is only in use while an item is held.
    a_sub_needs_item: assert property (@(posedge aclk) disable iff (!aresetn)
        sub_reg |-> in_valid_reg)
        else $error("second result pending with no item held");

    // Decoding never makes two results from one character.
    a_decode_single: assert property (@(posedge aclk) disable iff (!aresetn)
        direction_reg |-> !sub_reg)
        else $error("decode item stepped to a second result");

    // The drop state only exists in decode mode.
    a_failed_decode: assert property (@(posedge aclk) disable iff (!aresetn)
        failed_reg |-> direction_reg)
        else $error("drop state set while encoding");

    // An error result always closes the string.
    a_error_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("error result without end mark");
`endif

endmodule

`default_nettype wire
